// ----- hdl/aft_pkg.sv -----
package aft_pkg;

  localparam int unsigned DEF_NUM_SYMBOLS = 1280;
  localparam int unsigned DEF_FREQ_BITS   = 12;
  localparam int unsigned ESC_RESET_COUNT = 15;
  localparam int unsigned SYM_W           = 11;
  localparam int unsigned VAL_W           = 13;

  typedef enum logic [0:0] {
    CMD_COUNT  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SCALED = 2'd1,
    EV_HALVE  = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic clr_we;
    logic acc_rd;
    logic cnt_upd;
    logic walk_start;
    logic walk_rd;
    logic walk_we;
    logic walk_end;
    logic halve;
  } ctrl_t;

  typedef struct packed {
    logic need_walk;
    logic halve;
  } stat_t;

endpackage

// ----- hdl/aft_seq.sv -----
module aft_seq #(
  parameter int unsigned NUM_SYMBOLS = aft_pkg::DEF_NUM_SYMBOLS,
  localparam int unsigned IW = $clog2(NUM_SYMBOLS + 2)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        cmd_i,
  input  logic [aft_pkg::SYM_W-1:0]   symbol_i,
  input  logic                        out_free_i,
  input  aft_pkg::stat_t              stat_i,
  output logic                        in_ready_o,
  output aft_pkg::ctrl_t              ctrl_o,
  output logic [IW-1:0]               idx_o,
  output logic                        emit_o,
  output logic                        lookup_o,
  output aft_pkg::event_e             event_o
);

  localparam int unsigned TBL = NUM_SYMBOLS + 1;

  aft_pkg::state_e state_q, state_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic            lookup_q, lookup_d;
  logic            count_q, count_d;
  logic            halve_q, halve_d;
  aft_pkg::event_e ev_q, ev_d;
  logic            in_range;
  logic            accept;
  logic            walk_go;

  assign in_range = (32'(symbol_i) <= NUM_SYMBOLS);
  assign accept   = (state_q == aft_pkg::ST_IDLE) && in_valid_i;
  assign walk_go  = (state_q == aft_pkg::ST_FETCH) && count_q && stat_i.need_walk;

  always_comb begin
    state_d = state_q;
    case (state_q)
      aft_pkg::ST_CLEAR: begin
        if (idx_q == IW'(TBL - 1)) state_d = aft_pkg::ST_IDLE;
      end
      aft_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = aft_pkg::ST_FETCH;
      end
      aft_pkg::ST_FETCH: begin
        state_d = walk_go ? aft_pkg::ST_WALK : aft_pkg::ST_EMIT;
      end
      aft_pkg::ST_WALK: begin
        if (idx_q == IW'(TBL)) state_d = aft_pkg::ST_EMIT;
      end
      aft_pkg::ST_EMIT: begin
        if (out_free_i) state_d = aft_pkg::ST_IDLE;
      end
      default: state_d = aft_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.clr_we     = (state_q == aft_pkg::ST_CLEAR);
    ctrl_o.acc_rd     = accept;
    ctrl_o.cnt_upd    = (state_q == aft_pkg::ST_FETCH) && count_q;
    ctrl_o.walk_start = walk_go;
    ctrl_o.walk_rd    = (state_q == aft_pkg::ST_WALK) && (idx_q < IW'(TBL));
    ctrl_o.walk_we    = (state_q == aft_pkg::ST_WALK) && (idx_q != '0);
    ctrl_o.walk_end   = (state_q == aft_pkg::ST_WALK) && (idx_q == IW'(TBL));
    ctrl_o.halve      = halve_q;
    in_ready_o        = (state_q == aft_pkg::ST_IDLE);
    emit_o            = (state_q == aft_pkg::ST_EMIT) && out_free_i;
  end

  always_comb begin
    idx_d    = idx_q;
    lookup_d = lookup_q;
    count_d  = count_q;
    halve_d  = halve_q;
    ev_d     = ev_q;
    if (state_q == aft_pkg::ST_CLEAR || state_q == aft_pkg::ST_WALK) begin
      idx_d = idx_q + IW'(1);
    end
    if (accept) begin
      lookup_d = in_range && (cmd_i == aft_pkg::CMD_LOOKUP);
      count_d  = in_range && (cmd_i == aft_pkg::CMD_COUNT);
    end
    if (state_q == aft_pkg::ST_FETCH) begin
      idx_d   = '0;
      halve_d = stat_i.halve;
      if (walk_go) begin
        ev_d = stat_i.halve ? aft_pkg::EV_HALVE : aft_pkg::EV_SCALED;
      end else begin
        ev_d = aft_pkg::EV_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= aft_pkg::ST_CLEAR;
      idx_q    <= '0;
      lookup_q <= 1'b0;
      count_q  <= 1'b0;
      halve_q  <= 1'b0;
      ev_q     <= aft_pkg::EV_NONE;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      lookup_q <= lookup_d;
      count_q  <= count_d;
      halve_q  <= halve_d;
      ev_q     <= ev_d;
    end
  end

  assign idx_o    = idx_q;
  assign lookup_o = lookup_q;
  assign event_o  = ev_q;

endmodule

// ----- hdl/aft_dp.sv -----
module aft_dp #(
  parameter int unsigned NUM_SYMBOLS = aft_pkg::DEF_NUM_SYMBOLS,
  parameter int unsigned FREQ_BITS   = aft_pkg::DEF_FREQ_BITS,
  localparam int unsigned IW = $clog2(NUM_SYMBOLS + 2)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  aft_pkg::ctrl_t              ctrl_i,
  input  logic [IW-1:0]               idx_i,
  input  logic [aft_pkg::SYM_W-1:0]   symbol_i,
  output aft_pkg::stat_t              stat_o,
  output logic [aft_pkg::VAL_W-1:0]   rd_low_o,
  output logic [aft_pkg::VAL_W-1:0]   rd_width_o
);

  localparam int unsigned TBL     = NUM_SYMBOLS + 1;
  localparam int unsigned AW      = $clog2(TBL);
  localparam int unsigned CW      = FREQ_BITS + 1;
  localparam int unsigned EW      = $clog2(FREQ_BITS + 1);
  localparam int unsigned EXP_RST = (FREQ_BITS > 5) ? 5 : FREQ_BITS;
  localparam logic [CW-1:0] FULL     = {1'b1, {FREQ_BITS{1'b0}}};
  localparam logic [CW-1:0] WID_LAST = {1'b0, {FREQ_BITS{1'b1}}};
  localparam logic [CW-1:0] TOT_RST  = CW'(1 + aft_pkg::ESC_RESET_COUNT);

  logic [CW-1:0] cnt_mem [TBL];
  logic [CW-1:0] wid_mem [TBL];
  logic [CW-1:0] low_mem [TBL];

  logic [CW-1:0] rd_cnt_q, rd_wid_q, rd_low_q;
  logic [AW-1:0] sym_q, sym_d;
  logic [CW-1:0] total_q, total_d;
  logic [EW-1:0] exp_q, exp_d;
  logic [EW-1:0] shift_q, shift_d;
  logic [CW-1:0] acc_q, acc_d;
  logic [CW-1:0] tot_acc_q, tot_acc_d;

  logic [31:0]   sym_ext;
  logic [AW-1:0] sym_addr;
  logic [AW-1:0] idx_addr;
  logic [IW-1:0] widx_full;
  logic [AW-1:0] widx;
  logic [CW-1:0] cnt_new, tot_new, pow;
  logic          sat;
  logic [CW-1:0] wr_w, h_raw, h_val;
  logic          is_end;
  logic          cnt_we, pub_we, rd_en;
  logic [AW-1:0] cnt_waddr, pub_waddr, raddr;
  logic [CW-1:0] cnt_wdata, wid_wdata, low_wdata;
  logic [31:0]   low_ext, wid_ext;

  assign sym_ext   = 32'(symbol_i);
  assign sym_addr  = sym_ext[AW-1:0];
  assign idx_addr  = idx_i[AW-1:0];
  assign widx_full = idx_i - IW'(1);
  assign widx      = widx_full[AW-1:0];

  assign cnt_new = rd_cnt_q + CW'(1);
  assign tot_new = total_q + CW'(1);
  assign pow     = CW'(1) << exp_q;
  assign sat     = (exp_q == EW'(FREQ_BITS));
  assign stat_o.halve     = sat;
  assign stat_o.need_walk = sat ? (tot_new >= FULL) : (tot_new >= pow);

  assign wr_w   = rd_cnt_q << shift_q;
  assign h_raw  = rd_cnt_q >> 1;
  assign is_end = (widx == '0) || (widx == AW'(TBL - 1));
  assign h_val  = (is_end && (h_raw == '0)) ? CW'(1) : h_raw;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = sym_q;
    cnt_wdata = cnt_new;
    pub_we    = 1'b0;
    pub_waddr = widx;
    wid_wdata = wr_w;
    low_wdata = acc_q;
    if (ctrl_i.clr_we) begin
      cnt_we    = 1'b1;
      cnt_waddr = idx_addr;
      pub_we    = 1'b1;
      pub_waddr = idx_addr;
      if (idx_addr == '0) begin
        cnt_wdata = CW'(1);
        wid_wdata = CW'(1);
        low_wdata = '0;
      end else if (idx_addr == AW'(TBL - 1)) begin
        cnt_wdata = CW'(aft_pkg::ESC_RESET_COUNT);
        wid_wdata = WID_LAST;
        low_wdata = CW'(1);
      end else begin
        cnt_wdata = '0;
        wid_wdata = '0;
        low_wdata = CW'(1);
      end
    end else if (ctrl_i.cnt_upd) begin
      cnt_we = 1'b1;
    end else if (ctrl_i.walk_we) begin
      pub_we    = 1'b1;
      cnt_we    = ctrl_i.halve;
      cnt_waddr = widx;
      cnt_wdata = h_val;
    end
  end

  assign rd_en = ctrl_i.acc_rd || ctrl_i.walk_rd;
  assign raddr = ctrl_i.acc_rd ? sym_addr : idx_addr;

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (pub_we) begin
      wid_mem[pub_waddr] <= wid_wdata;
      low_mem[pub_waddr] <= low_wdata;
    end
    if (rd_en) begin
      rd_cnt_q <= cnt_mem[raddr];
      rd_wid_q <= wid_mem[raddr];
      rd_low_q <= low_mem[raddr];
    end
  end

  always_comb begin
    sym_d     = sym_q;
    total_d   = total_q;
    exp_d     = exp_q;
    shift_d   = shift_q;
    acc_d     = acc_q;
    tot_acc_d = tot_acc_q;
    if (ctrl_i.acc_rd) begin
      sym_d = sym_addr;
    end
    if (ctrl_i.cnt_upd) begin
      total_d = tot_new;
    end
    if (ctrl_i.walk_start) begin
      acc_d     = '0;
      tot_acc_d = '0;
      shift_d   = sat ? '0 : (EW'(FREQ_BITS) - exp_q);
      exp_d     = sat ? exp_q : (exp_q + EW'(1));
    end
    if (ctrl_i.walk_we) begin
      acc_d     = acc_q + wr_w;
      tot_acc_d = tot_acc_q + h_val;
      if (ctrl_i.walk_end && ctrl_i.halve) begin
        total_d = tot_acc_q + h_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOT_RST;
      exp_q   <= EW'(EXP_RST);
    end else begin
      total_q <= total_d;
      exp_q   <= exp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q     <= sym_d;
    shift_q   <= shift_d;
    acc_q     <= acc_d;
    tot_acc_q <= tot_acc_d;
  end

  assign low_ext    = 32'(rd_low_q);
  assign wid_ext    = 32'(rd_wid_q);
  assign rd_low_o   = low_ext[aft_pkg::VAL_W-1:0];
  assign rd_width_o = wid_ext[aft_pkg::VAL_W-1:0];

endmodule

// ----- hdl/adaptive_frequency_range_table_unit.sv -----
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    cmd_i, symbol_i
// out      out_valid_o / out_ready_i  range_low_o, range_width_o, table_event_o
//
// A lookup, an out-of-range item or a plain count goes from acceptance through the fetch
// state, which holds the registered table read, to the emit state, which loads the output
// register once it is free; the next item is then taken in the idle state. A count that
// triggers a rebuild adds a walk over the count memory, one entry per cycle through the
// shared scale and sum unit. After reset a clearing pass initializes the tables.
// A new item may be accepted while the previous result waits in the output register.
module adaptive_frequency_range_table_unit #(
  parameter int unsigned NUM_SYMBOLS = aft_pkg::DEF_NUM_SYMBOLS,
  parameter int unsigned FREQ_BITS   = aft_pkg::DEF_FREQ_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [aft_pkg::SYM_W-1:0]   symbol_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [aft_pkg::VAL_W-1:0]   range_low_o,
  output logic [aft_pkg::VAL_W-1:0]   range_width_o,
  output logic [1:0]                  table_event_o
);

  localparam int unsigned IW = $clog2(NUM_SYMBOLS + 2);

  aft_pkg::ctrl_t              ctrl;
  aft_pkg::stat_t              stat;
  logic [IW-1:0]               idx;
  logic                        emit;
  logic                        lookup;
  aft_pkg::event_e             ev;
  logic [aft_pkg::VAL_W-1:0]   rd_low, rd_width;
  logic                        out_free;

  logic                        out_valid_q, out_valid_d;
  logic [aft_pkg::VAL_W-1:0]   out_low_q, out_low_d;
  logic [aft_pkg::VAL_W-1:0]   out_width_q, out_width_d;
  aft_pkg::event_e             out_ev_q, out_ev_d;

  assign out_free = !out_valid_q || out_ready_i;

  aft_seq #(
    .NUM_SYMBOLS(NUM_SYMBOLS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .symbol_i   (symbol_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl),
    .idx_o      (idx),
    .emit_o     (emit),
    .lookup_o   (lookup),
    .event_o    (ev)
  );

  aft_dp #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .FREQ_BITS  (FREQ_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .idx_i      (idx),
    .symbol_i   (symbol_i),
    .stat_o     (stat),
    .rd_low_o   (rd_low),
    .rd_width_o (rd_width)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_low_d   = out_low_q;
    out_width_d = out_width_q;
    out_ev_d    = out_ev_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_low_d   = lookup ? rd_low : '0;
      out_width_d = lookup ? rd_width : '0;
      out_ev_d    = ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_low_q   <= out_low_d;
    out_width_q <= out_width_d;
    out_ev_q    <= out_ev_d;
  end

  assign out_valid_o   = out_valid_q;
  assign range_low_o   = out_low_q;
  assign range_width_o = out_width_q;
  assign table_event_o = out_ev_q;

endmodule

// ----- hdl/aft_checker.sv -----
module aft_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        cmd_i,
  input logic [aft_pkg::SYM_W-1:0]   symbol_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [aft_pkg::VAL_W-1:0]   range_low_o,
  input logic [aft_pkg::VAL_W-1:0]   range_width_o,
  input logic [1:0]                  table_event_o
);

  // The tables are being initialized right after reset, so no item is taken.
  a_no_accept_after_reset: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !in_ready_o
  ) else $error("input ready right after reset");

  // Only one item is in work at a time.
  a_one_in_flight: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o
  ) else $error("input ready in the cycle after an accepted item");

  // A result that reports a rebuild comes from a count and carries no range.
  a_event_no_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_event_o != aft_pkg::EV_NONE) |->
      (range_low_o == '0 && range_width_o == '0)
  ) else $error("rebuild result with nonzero range");

  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(range_low_o) && $stable(range_width_o) &&
       $stable(table_event_o))
  ) else $error("stalled result changed");

endmodule

bind adaptive_frequency_range_table_unit aft_checker u_aft_checker (.*);

// ----- dv/aft_checker.sv -----
`timescale 1ns / 1ps

module aft_scoreboard #(
  parameter int unsigned NUM_SYMBOLS = aft_pkg::DEF_NUM_SYMBOLS,
  parameter int unsigned FREQ_BITS   = aft_pkg::DEF_FREQ_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        cmd_i,
  input  logic [aft_pkg::SYM_W-1:0]   symbol_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [aft_pkg::VAL_W-1:0]   range_low_i,
  input  logic [aft_pkg::VAL_W-1:0]   range_width_i,
  input  logic [1:0]                  table_event_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          results_o
);

  typedef struct packed {
    logic [aft_pkg::VAL_W-1:0] low;
    logic [aft_pkg::VAL_W-1:0] width;
    aft_pkg::event_e           ev;
  } range_result_t;

  range_result_t expected_ranges[$];

  int unsigned sym_count [NUM_SYMBOLS+1];
  int unsigned pub_width [NUM_SYMBOLS+1];
  int unsigned pub_low   [NUM_SYMBOLS+1];
  int unsigned total_count;
  int unsigned exponent;
  int          fails;
  int          results;

  function automatic void publish_table(input int unsigned shift);
    int unsigned acc;
    acc = 0;
    for (int i = 0; i <= NUM_SYMBOLS; i++) begin
      pub_width[i] = sym_count[i] << shift;
      pub_low[i]   = acc;
      acc          = acc + pub_width[i];
    end
  endfunction

  function automatic range_result_t predict_range(input aft_pkg::cmd_e c,
                                                  input logic [aft_pkg::SYM_W-1:0] s);
    range_result_t r;
    int unsigned   sum;
    r    = '0;
    r.ev = aft_pkg::EV_NONE;
    if (s <= NUM_SYMBOLS) begin
      if (c == aft_pkg::CMD_LOOKUP) begin
        r.low   = aft_pkg::VAL_W'(pub_low[s]);
        r.width = aft_pkg::VAL_W'(pub_width[s]);
      end else begin
        sym_count[s] = sym_count[s] + 1;
        total_count  = total_count + 1;
        if (exponent < FREQ_BITS) begin
          if (total_count >= (32'd1 << exponent)) begin
            publish_table(FREQ_BITS - exponent);
            exponent = exponent + 1;
            r.ev     = aft_pkg::EV_SCALED;
          end
        end else if (total_count >= (32'd1 << FREQ_BITS)) begin
          publish_table(0);
          // Halve every count; the first and last entries never drop to zero.
          sum = 0;
          for (int i = 0; i <= NUM_SYMBOLS; i++) begin
            sym_count[i] = sym_count[i] >> 1;
            sum          = sum + sym_count[i];
          end
          if (sym_count[NUM_SYMBOLS] == 0) begin
            sym_count[NUM_SYMBOLS] = 1;
            sum                    = sum + 1;
          end
          if (sym_count[0] == 0) begin
            sym_count[0] = 1;
            sum          = sum + 1;
          end
          total_count = sum;
          r.ev        = aft_pkg::EV_HALVE;
        end
      end
    end
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    fails = fails + 1;
    if (fails <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    range_result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i <= NUM_SYMBOLS; i++) begin
        sym_count[i] = 0;
        pub_width[i] = 0;
        pub_low[i]   = (i == 0) ? 0 : 1;
      end
      sym_count[0]           = 1;
      sym_count[NUM_SYMBOLS] = aft_pkg::ESC_RESET_COUNT;
      total_count            = 1 + aft_pkg::ESC_RESET_COUNT;
      pub_width[0]           = 1;
      pub_width[NUM_SYMBOLS] = (32'd1 << FREQ_BITS) - 1;
      exponent = 0;
      while (exponent < FREQ_BITS && total_count >= (32'd1 << exponent)) begin
        exponent = exponent + 1;
      end
      expected_ranges.delete();
      fails   = 0;
      results = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results = results + 1;
        if (expected_ranges.size() == 0) begin
          note_failure($sformatf("result with nothing expected: low=%0d width=%0d event=%0d",
                                 range_low_i, range_width_i, table_event_i));
        end else begin
          exp_r = expected_ranges.pop_front();
          if (range_low_i !== exp_r.low || range_width_i !== exp_r.width ||
              table_event_i !== exp_r.ev) begin
            note_failure($sformatf(
              "mismatch: expected low=%0d width=%0d event=%0d, got low=%0d width=%0d event=%0d",
              exp_r.low, exp_r.width, exp_r.ev, range_low_i, range_width_i, table_event_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_ranges.push_back(predict_range(aft_pkg::cmd_e'(cmd_i), symbol_i));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_ranges.size();
    results_o    <= results;
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUM_SYMBOLS  = aft_pkg::DEF_NUM_SYMBOLS;
  localparam int unsigned FREQ_BITS    = aft_pkg::DEF_FREQ_BITS;
  localparam int          RANDOM_ITEMS = 1450;
  localparam int          TAIL_ITEMS   = 200;
  localparam int          STALL_LIMIT  = 20000;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  aft_pkg::cmd_e             cmd       = aft_pkg::CMD_COUNT;
  logic [aft_pkg::SYM_W-1:0] symbol    = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [aft_pkg::VAL_W-1:0] range_low;
  logic [aft_pkg::VAL_W-1:0] range_width;
  logic [1:0]                table_event;

  int fail_count;
  int pending;
  int results;
  bit calm      = 1'b0;
  bit hold_done = 1'b0;
  int stall_cycles = 0;

  adaptive_frequency_range_table_unit #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .FREQ_BITS  (FREQ_BITS)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd),
    .symbol_i     (symbol),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .range_low_o  (range_low),
    .range_width_o(range_width),
    .table_event_o(table_event)
  );

  aft_scoreboard #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .FREQ_BITS  (FREQ_BITS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .cmd_i        (cmd),
    .symbol_i     (symbol),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .range_low_i  (range_low),
    .range_width_i(range_width),
    .table_event_i(table_event),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_item(input aft_pkg::cmd_e c, input logic [aft_pkg::SYM_W-1:0] s);
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= c;
    symbol   <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic aft_pkg::cmd_e pick_cmd();
    return ($urandom_range(0, 99) < 85) ? aft_pkg::CMD_COUNT : aft_pkg::CMD_LOOKUP;
  endfunction

  // Counts favor a few hot symbols so that published widths grow large.
  function automatic logic [aft_pkg::SYM_W-1:0] pick_symbol(input aft_pkg::cmd_e c);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return aft_pkg::SYM_W'($urandom_range(1, 8));
    if (r < 80) return aft_pkg::SYM_W'($urandom_range(1, NUM_SYMBOLS - 1));
    if (r < 83) return aft_pkg::SYM_W'(NUM_SYMBOLS);
    if (r < 88 && c == aft_pkg::CMD_LOOKUP) return '0;
    if (r < 95) return aft_pkg::SYM_W'($urandom_range(1, NUM_SYMBOLS - 1));
    return aft_pkg::SYM_W'($urandom_range(NUM_SYMBOLS + 1, (1 << aft_pkg::SYM_W) - 1));
  endfunction

  initial begin
    int            n;
    aft_pkg::cmd_e c;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    send_item(aft_pkg::CMD_LOOKUP, '0);
    send_item(aft_pkg::CMD_LOOKUP, aft_pkg::SYM_W'(NUM_SYMBOLS));
    send_item(aft_pkg::CMD_LOOKUP, aft_pkg::SYM_W'(1));
    send_item(aft_pkg::CMD_LOOKUP, {aft_pkg::SYM_W{1'b1}});
    send_item(aft_pkg::CMD_COUNT, {aft_pkg::SYM_W{1'b1}});
    send_item(aft_pkg::CMD_COUNT, aft_pkg::SYM_W'(NUM_SYMBOLS + 1));
    send_item(aft_pkg::CMD_COUNT, '0);
    send_item(aft_pkg::CMD_COUNT, aft_pkg::SYM_W'(NUM_SYMBOLS));
    for (int i = 0; i < 14; i++) begin
      send_item(aft_pkg::CMD_COUNT,
                (i % 2 == 0) ? aft_pkg::SYM_W'(3) : aft_pkg::SYM_W'(1024));
    end
    send_item(aft_pkg::CMD_LOOKUP, '0);
    send_item(aft_pkg::CMD_LOOKUP, aft_pkg::SYM_W'(3));
    send_item(aft_pkg::CMD_LOOKUP, aft_pkg::SYM_W'(NUM_SYMBOLS));

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if ((n / 100) % 4 != 3 && $urandom_range(0, 99) < 30) begin
        idle_gap($urandom_range(1, 10));
      end
      c = pick_cmd();
      send_item(c, pick_symbol(c));
      n++;
    end
    calm = 1'b1;
    repeat (TAIL_ITEMS) begin
      c = pick_cmd();
      send_item(c, pick_symbol(c));
    end
    idle_gap(1);

    while (pending != 0) @(negedge clk);
    repeat (2 * NUM_SYMBOLS + 16) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS adaptive_frequency_range_table_unit");
    end else begin
      $display("FAIL adaptive_frequency_range_table_unit");
    end
    $finish;
  end

  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && results >= 400) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (burst > 0) begin
        burst--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 15) begin
        burst = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL adaptive_frequency_range_table_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
hdl/aft_pkg.sv
hdl/aft_seq.sv
hdl/aft_dp.sv
hdl/adaptive_frequency_range_table_unit.sv
hdl/aft_checker.sv
dv/aft_checker.sv
dv/tb_top.sv
